### hdl/jsd_pkg.sv
// Package with shared types, constants and a helper function for the distance unit.
`default_nettype none

package jsd_pkg;

    localparam int          MAX_LENGTH_DEFAULT  = 64;
    localparam logic [6:0]  VECTOR_LENGTH_RESET = 7'd64;
    localparam int          LOG_FRAC_BITS       = 26;
    localparam logic [27:0] LN2_Q28             = 28'd186065279;
    localparam logic [47:0] S32_LIMIT           = 48'h4_0000_0000;
    localparam logic [15:0] DIST_SAT            = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NEG  = 2'd1,
        STATUS_ZERO = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DIVP,
        S_DIVQ,
        S_TERM,
        S_LOG,
        S_MUL,
        S_ACC,
        S_FIN,
        S_ROOTI,
        S_ROOT
    } back_state_t;

    function automatic logic [4:0] msb_index(input logic [31:0] x);
        logic [4:0] e;
        e = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                e = 5'(i);
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

### hdl/jsd_fifo.sv
// Two-entry job queue between the intake stage and the compute engine.
`default_nettype none

module jsd_fifo
    import jsd_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      pop_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/jsd_front.sv
// Intake stage: stores element pairs, keeps the sums and queues one job per vector.
`default_nettype none

module jsd_front
    import jsd_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT,
    parameter int IDX_W      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    parameter int CNT_W      = $clog2(MAX_LENGTH + 1),
    parameter int TOTAL_W    = 33 + $clog2(MAX_LENGTH + 1),
    parameter int JOB_W      = CNT_W + 2 * TOTAL_W + 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [6:0]         cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] p_value,
    input  wire logic signed [31:0] q_value,
    output logic                    job_push,
    output logic [JOB_W-1:0]        job_data,
    input  wire logic               job_full,
    input  wire logic               job_done,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output logic [63:0]             rd_data
);

    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic [6:0]                vector_length_reg;
    logic [IDX_W-1:0]          count_reg;
    logic signed [TOTAL_W-1:0] p_total_reg;
    logic signed [TOTAL_W-1:0] q_total_reg;
    logic                      negative_reg;
    logic                      busy_reg;

    logic [31:0] p_mem [MAX_LENGTH];
    logic [31:0] q_mem [MAX_LENGTH];
    logic [63:0] rd_data_reg;

    logic                      accept;
    logic [CNT_W-1:0]          stored;
    logic [CMP_W-1:0]          len_eff;
    logic                      vector_end;
    logic signed [TOTAL_W-1:0] p_total_next;
    logic signed [TOTAL_W-1:0] q_total_next;
    logic                      negative_next;
    status_t                   job_status;

    assign in_ready = !busy_reg && !job_full;
    assign accept   = in_valid && in_ready;
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        stored        = CNT_W'(count_reg) + CNT_W'(1);
        p_total_next  = p_total_reg + TOTAL_W'(p_value);
        q_total_next  = q_total_reg + TOTAL_W'(q_value);
        negative_next = negative_reg || p_value[31] || q_value[31];
        if (vector_length_reg == 7'd0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (CMP_W'(vector_length_reg) > CMP_W'(MAX_LENGTH))
        begin
            len_eff = CMP_W'(MAX_LENGTH);
        end
        else
        begin
            len_eff = CMP_W'(vector_length_reg);
        end
        vector_end = (CMP_W'(stored) >= len_eff);
        if (negative_next)
        begin
            job_status = STATUS_NEG;
        end
        else if ((p_total_next == '0) || (q_total_next == '0))
        begin
            job_status = STATUS_ZERO;
        end
        else
        begin
            job_status = STATUS_OK;
        end
        job_push = accept && vector_end;
        job_data = {stored, p_total_next, q_total_next, job_status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= VECTOR_LENGTH_RESET;
            count_reg         <= '0;
            p_total_reg       <= '0;
            q_total_reg       <= '0;
            negative_reg      <= 1'b0;
            busy_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                vector_length_reg <= cfg_write_data;
            end
            if (job_done)
            begin
                busy_reg <= 1'b0;
            end
            if (accept)
            begin
                if (vector_end)
                begin
                    count_reg    <= '0;
                    p_total_reg  <= '0;
                    q_total_reg  <= '0;
                    negative_reg <= 1'b0;
                    busy_reg     <= (job_status == STATUS_OK);
                end
                else
                begin
                    count_reg    <= IDX_W'(stored);
                    p_total_reg  <= p_total_next;
                    q_total_reg  <= q_total_next;
                    negative_reg <= negative_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_mem[count_reg] <= p_value;
            q_mem[count_reg] <= q_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= {p_mem[rd_addr], q_mem[rd_addr]};
        end
    end

endmodule

`default_nettype wire

### hdl/jsd_back.sv
// Compute engine: shared divider, logarithm, multiply-accumulate and square root.
`default_nettype none

module jsd_back
    import jsd_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT,
    parameter int IDX_W      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    parameter int CNT_W      = $clog2(MAX_LENGTH + 1),
    parameter int TOTAL_W    = 33 + $clog2(MAX_LENGTH + 1),
    parameter int JOB_W      = CNT_W + 2 * TOTAL_W + 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire logic [JOB_W-1:0] job_data,
    output logic                  job_pop,
    output logic                  job_done,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  wire logic [63:0]      rd_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [15:0]           distance,
    output status_t               status
);

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]   job_len_reg;
    logic [TOTAL_W-1:0] p_div_reg;
    logic [TOTAL_W-1:0] q_div_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               term_sel_reg;
    logic               log_phase_reg;
    logic [4:0]         cnt_reg;
    logic [TOTAL_W-1:0] rem_reg;
    logic [30:0]        low_reg;
    logic [30:0]        quo_reg;
    logic [31:0]        q_hold_reg;
    logic [30:0]        pn_reg;
    logic [30:0]        qn_reg;
    logic [31:0]        m_reg;
    logic [25:0]        frac_reg;
    logic [4:0]         exp_reg;
    logic [30:0]        l1_reg;
    logic [30:0]        l2_reg;
    logic [62:0]        prod_reg;
    logic               prod_neg_reg;
    logic signed [55:0] acc_reg;
    logic [62:0]        vprod_reg;
    logic [33:0]        v_reg;
    logic [33:0]        res_reg;
    logic               out_valid_reg;
    logic [15:0]        distance_reg;
    status_t            status_reg;

    logic [CNT_W-1:0]   job_len;
    logic [TOTAL_W-1:0] job_p_total;
    logic [TOTAL_W-1:0] job_q_total;
    status_t            job_status;

    logic [TOTAL_W-1:0] divisor;
    logic [TOTAL_W:0]   rem_shift;
    logic               div_ge;
    logic [TOTAL_W-1:0] rem_step;
    logic [30:0]        quo_step;
    logic [30:0]        a_cur;
    logic [30:0]        b_cur;
    logic [31:0]        x_setup;
    logic [4:0]         e_setup;
    logic [31:0]        m_setup;
    logic [63:0]        sq;
    logic [32:0]        sq_t;
    logic [25:0]        frac_step;
    logic [31:0]        m_step;
    logic signed [31:0] d_log;
    logic [31:0]        d_mag;
    logic [46:0]        term_mag;
    logic [55:0]        s_pos;
    logic [47:0]        s32;
    logic [34:0]        s32_lim;
    logic [33:0]        root_bit;
    logic [34:0]        root_try;
    logic               root_ge;
    logic [33:0]        res_step;
    logic [33:0]        v_step;
    logic               last_elem;

    assign {job_len, job_p_total, job_q_total, job_status} = job_data;

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign status    = status_reg;

    always_comb
    begin
        divisor   = (state_reg == S_DIVP) ? p_div_reg : q_div_reg;
        rem_shift = {rem_reg, low_reg[30]};
        div_ge    = (rem_shift >= {1'b0, divisor});
        rem_step  = div_ge ? TOTAL_W'(rem_shift - {1'b0, divisor})
                           : TOTAL_W'(rem_shift);
        quo_step  = {quo_reg[29:0], div_ge};

        a_cur   = term_sel_reg ? qn_reg : pn_reg;
        b_cur   = term_sel_reg ? pn_reg : qn_reg;
        x_setup = (state_reg == S_TERM) ? {a_cur, 1'b0}
                                        : (32'(a_cur) + 32'(b_cur));
        e_setup = msb_index(x_setup);
        m_setup = x_setup << (5'd31 - e_setup);

        sq        = 64'(m_reg) * 64'(m_reg);
        sq_t      = sq[63:31];
        frac_step = {frac_reg[24:0], sq_t[32]};
        m_step    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];

        d_log    = signed'({1'b0, l1_reg}) - signed'({1'b0, l2_reg});
        d_mag    = d_log[31] ? 32'(-d_log) : 32'(d_log);
        term_mag = prod_reg[62:16];

        s_pos   = acc_reg[55] ? 56'd0 : 56'(acc_reg);
        s32     = s_pos[55:8];
        s32_lim = (s32 > S32_LIMIT) ? 35'(S32_LIMIT) : 35'(s32);

        root_bit = 34'd1 << {cnt_reg, 1'b0};
        root_try = 35'(res_reg) + 35'(root_bit);
        root_ge  = ({1'b0, v_reg} >= root_try);
        v_step   = root_ge ? 34'({1'b0, v_reg} - root_try) : v_reg;
        res_step = root_ge ? ((res_reg >> 1) + root_bit) : (res_reg >> 1);

        last_elem = ((idx_reg + CNT_W'(1)) == job_len_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid && !out_valid_reg && (job_status == STATUS_OK))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_WAIT;
            S_WAIT:  state_next = S_DIVP;
            S_DIVP:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_DIVQ;
                end
            end
            S_DIVQ:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                if (a_cur != 31'd0)
                begin
                    state_next = S_LOG;
                end
                else if (term_sel_reg)
                begin
                    state_next = last_elem ? S_FIN : S_READ;
                end
            end
            S_LOG:
            begin
                if ((cnt_reg == 5'd0) && log_phase_reg)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_ACC;
            S_ACC:
            begin
                if (term_sel_reg)
                begin
                    state_next = last_elem ? S_FIN : S_READ;
                end
                else
                begin
                    state_next = S_TERM;
                end
            end
            S_FIN:   state_next = S_ROOTI;
            S_ROOTI: state_next = S_ROOT;
            S_ROOT:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop  = (state_reg == S_IDLE) && job_valid && !out_valid_reg;
        rd_en    = (state_reg == S_READ);
        rd_addr  = IDX_W'(idx_reg);
        job_done = (state_reg == S_ROOT) && (cnt_reg == 5'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (job_pop && (job_status != STATUS_OK))
            begin
                out_valid_reg <= 1'b1;
            end
            if (job_done)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (job_pop)
                begin
                    job_len_reg  <= job_len;
                    p_div_reg    <= job_p_total;
                    q_div_reg    <= job_q_total;
                    idx_reg      <= '0;
                    acc_reg      <= '0;
                    distance_reg <= DIST_SAT;
                    status_reg   <= job_status;
                end
            end
            S_WAIT:
            begin
                rem_reg    <= TOTAL_W'(rd_data[63:33]);
                low_reg    <= {rd_data[32], 30'd0};
                q_hold_reg <= rd_data[31:0];
                cnt_reg    <= 5'd30;
            end
            S_DIVP:
            begin
                if (cnt_reg == 5'd0)
                begin
                    pn_reg  <= quo_step;
                    rem_reg <= TOTAL_W'(q_hold_reg[31:1]);
                    low_reg <= {q_hold_reg[0], 30'd0};
                    cnt_reg <= 5'd30;
                end
                else
                begin
                    rem_reg <= rem_step;
                    low_reg <= {low_reg[29:0], 1'b0};
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            S_DIVQ:
            begin
                if (cnt_reg == 5'd0)
                begin
                    qn_reg       <= quo_step;
                    term_sel_reg <= 1'b0;
                end
                else
                begin
                    rem_reg <= rem_step;
                    low_reg <= {low_reg[29:0], 1'b0};
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            S_TERM:
            begin
                if (a_cur != 31'd0)
                begin
                    m_reg         <= m_setup;
                    exp_reg       <= e_setup;
                    frac_reg      <= '0;
                    log_phase_reg <= 1'b0;
                    cnt_reg       <= 5'(LOG_FRAC_BITS - 1);
                end
                else if (term_sel_reg)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                else
                begin
                    term_sel_reg <= 1'b1;
                end
            end
            S_LOG:
            begin
                if (cnt_reg == 5'd0)
                begin
                    if (log_phase_reg)
                    begin
                        l2_reg <= {exp_reg, frac_step};
                    end
                    else
                    begin
                        l1_reg        <= {exp_reg, frac_step};
                        m_reg         <= m_setup;
                        exp_reg       <= e_setup;
                        frac_reg      <= '0;
                        log_phase_reg <= 1'b1;
                        cnt_reg       <= 5'(LOG_FRAC_BITS - 1);
                    end
                end
                else
                begin
                    m_reg    <= m_step;
                    frac_reg <= frac_step;
                    cnt_reg  <= cnt_reg - 5'd1;
                end
            end
            S_MUL:
            begin
                prod_reg     <= 63'(a_cur) * 63'(d_mag);
                prod_neg_reg <= d_log[31];
            end
            S_ACC:
            begin
                if (prod_neg_reg)
                begin
                    acc_reg <= acc_reg - signed'(56'(term_mag));
                end
                else
                begin
                    acc_reg <= acc_reg + signed'(56'(term_mag));
                end
                if (term_sel_reg)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                else
                begin
                    term_sel_reg <= 1'b1;
                end
            end
            S_FIN:
            begin
                vprod_reg <= 63'(s32_lim) * 63'(LN2_Q28);
            end
            S_ROOTI:
            begin
                v_reg   <= vprod_reg[62:29];
                res_reg <= '0;
                cnt_reg <= 5'd16;
            end
            S_ROOT:
            begin
                v_reg   <= v_step;
                res_reg <= res_step;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    distance_reg <= (res_step > 34'd65535) ? DIST_SAT : res_step[15:0];
                    status_reg   <= STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> ($past(state_reg) == S_MUL))
        else $error("accumulate step without a preceding multiply");

    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> out_valid_reg)
        else $error("finished job did not produce a result");

    a_error_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |-> (distance_reg == DIST_SAT))
        else $error("error result without saturated distance");

    a_busy_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("engine working while a result is still pending");

endmodule

`default_nettype wire

### hdl/jensen_shannon_distance_top.sv
// Top level of the Jensen-Shannon distance unit: intake stage, job queue and compute engine.
// Pairs go in one per cycle while in_ready is high until a vector ends; its result follows later.
// A vector with an error status is queued like any other but presented without computing.
// A valid vector is handled pair by pair by bit-serial division, squaring logarithms and a
// multiply-accumulate, then scaled and square-rooted in the shared compute engine.
// After a valid vector, the next one is held off until the engine has finished it.
// Reset is asynchronous and active low; it clears sums, counters, queue and vector_length=64.
`default_nettype none

module jensen_shannon_distance_top
    import jsd_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [6:0]         cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] p_value,
    input  wire logic signed [31:0] q_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             distance,
    output logic [1:0]              status
);

    localparam int IDX_W   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CNT_W   = $clog2(MAX_LENGTH + 1);
    localparam int TOTAL_W = 33 + $clog2(MAX_LENGTH + 1);
    localparam int JOB_W   = CNT_W + 2 * TOTAL_W + 2;

    logic             job_push;
    logic [JOB_W-1:0] job_push_data;
    logic             job_full;
    logic             job_pop;
    logic             job_valid;
    logic [JOB_W-1:0] job_pop_data;
    logic             job_done;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [63:0]      rd_data;
    status_t          status_out;

    assign status = status_out;

    jsd_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .TOTAL_W    (TOTAL_W),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .p_value        (p_value),
        .q_value        (q_value),
        .job_push       (job_push),
        .job_data       (job_push_data),
        .job_full       (job_full),
        .job_done       (job_done),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    jsd_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_push_data),
        .full      (job_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job_pop_data)
    );

    jsd_back #(
        .MAX_LENGTH (MAX_LENGTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .TOTAL_W    (TOTAL_W),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_data  (job_pop_data),
        .job_pop   (job_pop),
        .job_done  (job_done),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .status    (status_out)
    );

endmodule

`default_nettype wire

### dv/tb_jensen_shannon_distance_top.sv
// Self-checking testbench for the Jensen-Shannon distance unit with a built-in predictor.
`timescale 1ns / 1ps

module tb_jensen_shannon_distance_top;
    import jsd_pkg::*;

    localparam int MAX_LEN = 64;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 4000;

    typedef struct packed {
        logic [15:0] dist_val;
        status_t     stat;
    } jsd_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [6:0]         cfg_write_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] p_value;
    logic signed [31:0] q_value;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        distance;
    logic [1:0]         status;

    jsd_result_t expected_dist_q[$];

    logic [31:0] p_mem [MAX_LEN];
    logic [31:0] q_mem [MAX_LEN];
    longint      p_sum;
    longint      q_sum;
    int          pair_count;
    bit          neg_flag;
    logic [6:0]  length_reg;

    int sender_idle_pct;
    int stall_pct;
    int hold_req_count;
    int hold_done;
    int hold_left;
    int mismatch_count;
    int results_checked;
    int pairs_sent;
    int status_seen [3];

    jensen_shannon_distance_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .p_value        (p_value),
        .q_value        (q_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distance       (distance),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] log2_q26(input logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        frac = 64'd0;
        if (x == 64'd0)
        begin
            return 64'd0;
        end
        while (e < 63 && (x >> (e + 1)) != 64'd0)
        begin
            e++;
        end
        m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
        for (int k = 0; k < LOG_FRAC_BITS; k++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << LOG_FRAC_BITS) | frac;
    endfunction

    function automatic longint weighted_log_ratio(input logic [63:0] a, input logic [63:0] b);
        longint      d;
        logic [63:0] mag;
        logic [63:0] prod;
        d = longint'(log2_q26(2 * a)) - longint'(log2_q26(a + b));
        mag = (d < 0) ? 64'(-d) : 64'(d);
        prod = (a * mag) >> 16;
        return (d < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] js_distance(input int n);
        longint      s;
        logic [63:0] pn;
        logic [63:0] qn;
        logic [63:0] s32;
        logic [63:0] v;
        logic [63:0] root;
        s = 0;
        for (int i = 0; i < n; i++)
        begin
            pn = (64'(longint'($signed(p_mem[i]))) << 30) / 64'(p_sum);
            qn = (64'(longint'($signed(q_mem[i]))) << 30) / 64'(q_sum);
            if (pn > 0)
            begin
                s += weighted_log_ratio(pn, qn);
            end
            if (qn > 0)
            begin
                s += weighted_log_ratio(qn, pn);
            end
        end
        if (s < 0)
        begin
            s = 0;
        end
        s32 = 64'(s) >> 8;
        if (s32 > 64'(S32_LIMIT))
        begin
            s32 = 64'(S32_LIMIT);
        end
        v = (s32 * 64'(LN2_Q28)) >> 29;
        root = int_sqrt(v);
        return (root > 64'd65535) ? DIST_SAT : root[15:0];
    endfunction

    function automatic void predict_pair(input logic [31:0] pv, input logic [31:0] qv);
        int          len;
        int          idx;
        jsd_result_t r;
        len = int'(length_reg);
        if (len < 1)
        begin
            len = 1;
        end
        if (len > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        idx = (pair_count >= MAX_LEN) ? MAX_LEN - 1 : pair_count;
        p_mem[idx] = pv;
        q_mem[idx] = qv;
        if (pv[31] || qv[31])
        begin
            neg_flag = 1'b1;
        end
        p_sum += longint'($signed(pv));
        q_sum += longint'($signed(qv));
        if (idx + 1 < len)
        begin
            pair_count = idx + 1;
            return;
        end
        if (neg_flag)
        begin
            r.dist_val = DIST_SAT;
            r.stat = STATUS_NEG;
        end
        else if (p_sum == 0 || q_sum == 0)
        begin
            r.dist_val = DIST_SAT;
            r.stat = STATUS_ZERO;
        end
        else
        begin
            r.dist_val = js_distance(idx + 1);
            r.stat = STATUS_OK;
        end
        expected_dist_q.push_back(r);
        p_sum = 0;
        q_sum = 0;
        pair_count = 0;
        neg_flag = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dist_q.size() == 0)
            begin
                report_mismatch("unexpected result, distance", distance, -1);
            end
            else
            begin
                jsd_result_t r;
                r = expected_dist_q.pop_front();
                results_checked++;
                if (status != r.stat)
                begin
                    report_mismatch("status", status, r.stat);
                end
                if (distance != r.dist_val)
                begin
                    report_mismatch("distance", distance, r.dist_val);
                end
                if (r.stat <= STATUS_ZERO)
                begin
                    status_seen[r.stat]++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req_count != hold_done)
        begin
            hold_done = hold_req_count;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_pair(input logic [31:0] pv, input logic [31:0] qv);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        p_value <= pv;
        q_value <= qv;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_pair(pv, qv);
        pairs_sent++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (expected_dist_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [6:0] len);
        drain();
        cfg_write_en <= 1'b1;
        cfg_write_data <= len;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        length_reg = len;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0; stall_pct = 0; end
            1: begin sender_idle_pct = 56; stall_pct = 0; end
            2: begin sender_idle_pct = 0; stall_pct = 56; end
            default: begin sender_idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    function automatic logic [31:0] pick_value(input bit allow_neg);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1, 2: return $urandom_range(1, 255);
            3, 4: return $urandom_range(0, 32'h0001_0000);
            5: return 32'h7FFF_FFFF;
            6: return allow_neg ? $urandom : ($urandom & 32'h7FFF_FFFF);
            default: return $urandom & 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic send_vector(input int len, input int kind);
        int bad_at;
        bad_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                1: send_pair(pick_value(0), (i == bad_at) ? ($urandom | 32'h8000_0000)
                                                          : pick_value(0));
                2: send_pair(32'd0, pick_value(0));
                3: send_pair($urandom, $urandom);
                default: send_pair(pick_value(0), pick_value(0) | 32'(i == bad_at));
            endcase
        end
    endtask

    task automatic test_directed();
        set_idling(0);
        write_length(7'd1);
        send_pair(32'd0, 32'd0);
        send_pair(32'd1, 32'd1);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'd0);
        send_pair(32'h8000_0000, 32'd5);
        send_pair(32'd5, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'd0);
        write_length(7'd2);
        send_pair(32'd1, 32'd0);
        send_pair(32'd0, 32'd1);
        send_pair(32'h0001_0000, 32'h0003_0000);
        send_pair(32'h0003_0000, 32'h0001_0000);
        send_pair(32'd0, 32'd7);
        send_pair(32'd0, 32'd9);
        write_length(7'd0);
        send_pair(32'd3, 32'd4);
        send_pair(32'd0, 32'd0);
    endtask

    task automatic test_length_extremes();
        logic [6:0] lens [5] = '{7'd64, 7'd65, 7'd127, 7'd63, 7'd3};
        set_idling(3);
        foreach (lens[i])
        begin
            write_length(lens[i]);
            send_vector((lens[i] > 7'd64) ? MAX_LEN : int'(lens[i]), 0);
        end
    endtask

    task automatic test_length_lowered();
        set_idling(0);
        write_length(7'd8);
        for (int i = 0; i < 5; i++)
        begin
            send_pair(pick_value(0), pick_value(0) | 32'd1);
        end
        write_length(7'd3);
        send_pair(pick_value(0), pick_value(0));
        write_length(7'd6);
        send_pair(32'd10, 32'd20);
        send_pair(32'd30, 32'd40);
        write_length(7'd1);
        send_pair(32'd50, 32'd60);
    endtask

    task automatic test_backpressure();
        set_idling(0);
        write_length(7'd1);
        hold_req_count <= hold_req_count + 1;
        for (int i = 0; i < 40; i++)
        begin
            send_vector(1, ($urandom_range(0, 9) == 0) ? 1 : 0);
        end
    endtask

    task automatic test_random();
        int len;
        int kind;
        int roll;
        while (pairs_sent < 2000)
        begin
            roll = $urandom_range(0, 99);
            len = (roll < 80) ? $urandom_range(1, 8) :
                  (roll < 96) ? $urandom_range(9, 32) : MAX_LEN;
            write_length(7'(len));
            set_idling($urandom_range(0, 3));
            for (int v = 0; v < 4; v++)
            begin
                roll = $urandom_range(0, 99);
                kind = (roll < 80) ? 0 : (roll < 88) ? 1 : (roll < 94) ? 2 : 3;
                send_vector(len, kind);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 7'd0;
        in_valid = 1'b0;
        p_value = '0;
        q_value = '0;
        out_ready = 1'b0;
        sender_idle_pct = 0;
        stall_pct = 0;
        hold_req_count = 0;
        hold_done = 0;
        hold_left = 0;
        mismatch_count = 0;
        results_checked = 0;
        pairs_sent = 0;
        status_seen = '{0, 0, 0};
        p_sum = 0;
        q_sum = 0;
        pair_count = 0;
        neg_flag = 1'b0;
        length_reg = VECTOR_LENGTH_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_length_extremes();
        test_length_lowered();
        test_backpressure();
        test_random();
        drain();
        $display("Sent %0d pairs over lengths 0 to 127; checked %0d distances", pairs_sent,
                 results_checked);
        $display("Status counts: ok %0d, negative %0d, zero sum %0d", status_seen[0],
                 status_seen[1], status_seen[2]);
        if (mismatch_count == 0 && expected_dist_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("Timeout with %0d results outstanding", expected_dist_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
hdl/jsd_pkg.sv
hdl/jsd_fifo.sv
hdl/jsd_front.sv
hdl/jsd_back.sv
hdl/jensen_shannon_distance_top.sv
dv/tb_jensen_shannon_distance_top.sv
